@@ src/two_plane_blitter_with_layer_masks_defines.svh @@
// Assertion helpers used by the top-level file of this block.
`ifndef TWO_PLANE_BLITTER_WITH_LAYER_MASKS_DEFINES_SVH
`define TWO_PLANE_BLITTER_WITH_LAYER_MASKS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

// Next-cycle implication, checked outside reset.
`define TPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons one cycle later");

`endif

@@ src/tpb_pkg.sv @@
package tpb_pkg;

  localparam int RamAw      = 14;
  localparam int RamWords   = 1 << RamAw;
  localparam int RomPlaneAw = 13;
  localparam int RomPlaneSz = 1 << RomPlaneAw;
  localparam int QDepth     = 2;  // must be a power of two
  localparam int QPtrW      = $clog2(QDepth);

  localparam logic [RamAw-1:0] RowStride = RamAw'(256);

  typedef enum logic [1:0] {
    ACT_BYTE_WRITE = 2'd0,
    ACT_BLIT       = 2'd1,
    ACT_ROM_LOAD   = 2'd2,
    ACT_READ       = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    CFG_BLIT_SOURCE = 2'd0,
    CFG_BLIT_DEST   = 2'd1,
    CFG_BLIT_WIDTH  = 2'd2,
    CFG_LAYER_MASK  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [13:0] address;
    logic [7:0]  byte_value;
    logic [7:0]  blit_height;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic        was_read;
  } result_t;

  typedef struct packed {
    logic [15:0] blit_source;
    logic [15:0] blit_dest;
    logic [7:0]  blit_width;
    logic [3:0]  layer_mask;
  } cfg_t;

  typedef struct packed {
    act_e        op;
    logic [13:0] address;
    logic [7:0]  byte_value;
    logic [7:0]  blit_height;
  } q_item_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  // Each low bit gives a 0x55 pattern and each high bit a 0xaa pattern in its byte lane.
  function automatic logic [31:0] expand_pix(input logic [7:0] v);
    logic [31:0] p;
    p = '0;
    for (int l = 0; l < 4; l++) begin
      p[8*l +: 8] = (v[l] ? 8'h55 : 8'h00) | (v[l+4] ? 8'haa : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [31:0] lane_sel(input logic [3:0] m);
    logic [7:0] b;
    b = (m[3] ? 8'h30 : 8'h00) | (m[2] ? 8'hc0 : 8'h00) |
        (m[1] ? 8'h03 : 8'h00) | (m[0] ? 8'h0c : 8'h00);
    return {4{b}};
  endfunction

  function automatic logic [3:0] widen_mask(input logic [3:0] m);
    return {{2{|m[3:2]}}, {2{|m[1:0]}}};
  endfunction

endpackage

@@ src/two_plane_blitter_with_layer_masks.sv @@
// Video RAM blitter with a two-plane graphics ROM and a 4-bit layer mask.
// Items enter on start_i with item_i and are taken at an edge where busy_o is
// low; a two-entry queue sits between the decoder and the RAM sequencer.
// Every item gives exactly one result: done_o is high for one cycle with
// result_o, and the receiver cannot hold it off. Only reads carry data.
// Registers are written through cfg_we_i, cfg_index_i and cfg_data_i at any
// edge with the write enable high, and should change only while idle.
// A back-to-back stream runs at one ROM load per cycle while the sequencer
// stays in S_IDLE; it pops the next queued item only from S_IDLE, so it takes
// no new item during S_MERGE, S_READ_OUT or S_BLIT_RD and S_BLIT_WR.
// The single video RAM read port sets this: every pixel and every byte write
// is a read followed by a merged write. After reset the video RAM is swept to
// zero, one word per cycle over all 16384 words, with busy_o high; register
// writes are taken during the sweep. The graphics ROM keeps its contents over
// reset and must be loaded first.
`include "two_plane_blitter_with_layer_masks_defines.svh"

module two_plane_blitter_with_layer_masks (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tpb_pkg::in_item_t item_i,
  output logic              busy_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output logic              done_o,
  output tpb_pkg::result_t  result_o
);
  import tpb_pkg::*;

  back_stat_t stat;
  logic       q_valid;
  q_item_t    q_item;
  cfg_t       cfg;

  tpb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .stat_i     (stat),
    .busy_o     (busy_o),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .cfg_o      (cfg)
  );

  tpb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_item_i (q_item),
    .cfg_i    (cfg),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

  `TPB_ASSERT_IMPL(a_clear_blocks_input, clk_i, rst_ni, stat.clearing, busy_o)
  `TPB_ASSERT_IMPL(a_pop_needs_entry, clk_i, rst_ni, stat.pop, q_valid)
  `TPB_ASSERT_IMPL(a_nonread_zero, clk_i, rst_ni, done_o && !result_o.was_read, result_o.read_word == '0)
  `TPB_ASSERT_NEXT(a_pop_no_result_same, clk_i, rst_ni, stat.pop && (q_item.op == ACT_READ), !done_o)

endmodule

@@ src/tpb_front.sv @@
module tpb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tpb_pkg::in_item_t   item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  tpb_pkg::back_stat_t stat_i,
  output logic                busy_o,
  output logic                q_valid_o,
  output tpb_pkg::q_item_t    q_item_o,
  output tpb_pkg::cfg_t       cfg_o
);
  import tpb_pkg::*;

  q_item_t          fifo_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q, count_d;
  cfg_t             cfg_q;
  logic             push;
  q_item_t          new_item;

  assign busy_o    = (count_q == (QPtrW + 1)'(QDepth)) | stat_i.clearing;
  assign push      = start_i & ~busy_o;
  assign q_valid_o = (count_q != '0);
  assign q_item_o  = fifo_q[rd_ptr_q];
  assign cfg_o     = cfg_q;

  always_comb begin
    new_item.op          = act_e'(item_i.action);
    new_item.address     = item_i.address;
    new_item.byte_value  = item_i.byte_value;
    new_item.blit_height = item_i.blit_height;
  end

  always_comb begin
    count_d = count_q;
    if (push && !stat_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (!push && stat_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      cfg_q    <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (stat_i.pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_BLIT_SOURCE: cfg_q.blit_source <= cfg_data_i;
          CFG_BLIT_DEST:   cfg_q.blit_dest   <= cfg_data_i;
          CFG_BLIT_WIDTH:  cfg_q.blit_width  <= cfg_data_i[7:0];
          CFG_LAYER_MASK:  cfg_q.layer_mask  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

@@ src/tpb_back.sv @@
module tpb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  tpb_pkg::q_item_t    q_item_i,
  input  tpb_pkg::cfg_t       cfg_i,
  output tpb_pkg::back_stat_t stat_o,
  output logic                done_o,
  output tpb_pkg::result_t    result_o
);
  import tpb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MERGE,
    S_READ_OUT,
    S_BLIT_RD,
    S_BLIT_WR
  } state_e;

  state_e                state_q;
  logic [RamAw-1:0]      clr_q;
  logic [RamAw-1:0]      addr_q;
  logic [7:0]            val_q;
  logic [31:0]           sel_q;
  logic [RomPlaneAw-1:0] src_q;
  logic [RamAw-1:0]      row_q;
  logic [7:0]            x_q, y_q, h_q;
  logic [31:0]           sel0_q, sel1_q;
  logic                  done_q;
  result_t               res_q;

  logic [31:0] ram_mem [RamWords];
  logic [7:0]  rom0_mem [RomPlaneSz];
  logic [7:0]  rom1_mem [RomPlaneSz];
  logic [31:0] ram_rdata_q;
  logic [7:0]  rom0_rdata_q, rom1_rdata_q;

  logic             pop;
  logic [RamAw-1:0] blit_addr, ram_raddr, ram_waddr;
  logic             ram_we;
  logic [31:0]      ram_wdata;
  logic             rom_we;
  logic [3:0]       wide_mask;

  assign pop       = (state_q == S_IDLE) & q_valid_i;
  assign blit_addr = row_q + {{(RamAw - 8){1'b0}}, x_q};
  assign ram_raddr = (state_q == S_IDLE) ? q_item_i.address : blit_addr;
  assign rom_we    = pop & (q_item_i.op == ACT_ROM_LOAD);
  assign wide_mask = widen_mask(cfg_i.layer_mask);

  assign stat_o.clearing = (state_q == S_CLEAR);
  assign stat_o.pop      = pop;
  assign done_o          = done_q;
  assign result_o        = res_q;

  // The two plane masks of a blit select disjoint bits, so both planes merge in one write.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = blit_addr;
    ram_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      S_MERGE: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = (ram_rdata_q & ~sel_q) | (expand_pix(val_q) & sel_q);
      end
      S_BLIT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata_q & ~(sel0_q | sel1_q)) |
                    (expand_pix(rom0_rdata_q) & sel0_q) |
                    (expand_pix(rom1_rdata_q) & sel1_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
    ram_rdata_q <= ram_mem[ram_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rom_we && !q_item_i.address[RomPlaneAw]) begin
      rom0_mem[q_item_i.address[RomPlaneAw-1:0]] <= q_item_i.byte_value;
    end
    rom0_rdata_q <= rom0_mem[src_q];
  end

  always_ff @(posedge clk_i) begin
    if (rom_we && q_item_i.address[RomPlaneAw]) begin
      rom1_mem[q_item_i.address[RomPlaneAw-1:0]] <= q_item_i.byte_value;
    end
    rom1_rdata_q <= rom1_mem[src_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      addr_q  <= '0;
      val_q   <= '0;
      sel_q   <= '0;
      src_q   <= '0;
      row_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      h_q     <= '0;
      sel0_q  <= '0;
      sel1_q  <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      res_q  <= '0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            addr_q <= q_item_i.address;
            val_q  <= q_item_i.byte_value;
            unique case (q_item_i.op)
              ACT_BYTE_WRITE: begin
                sel_q   <= lane_sel(cfg_i.layer_mask);
                state_q <= S_MERGE;
              end
              ACT_BLIT: begin
                src_q   <= cfg_i.blit_source[RomPlaneAw-1:0];
                row_q   <= cfg_i.blit_dest[RamAw-1:0];
                x_q     <= '0;
                y_q     <= '0;
                h_q     <= q_item_i.blit_height;
                sel0_q  <= lane_sel(wide_mask & 4'h5);
                sel1_q  <= lane_sel(wide_mask & 4'ha);
                state_q <= S_BLIT_RD;
              end
              ACT_ROM_LOAD: begin
                done_q <= 1'b1;
              end
              ACT_READ: begin
                state_q <= S_READ_OUT;
              end
              default: ;
            endcase
          end
        end
        S_MERGE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_READ_OUT: begin
          done_q          <= 1'b1;
          res_q.read_word <= ram_rdata_q;
          res_q.was_read  <= 1'b1;
          state_q         <= S_IDLE;
        end
        S_BLIT_RD: begin
          state_q <= S_BLIT_WR;
        end
        S_BLIT_WR: begin
          src_q <= src_q + 1'b1;
          if (x_q == cfg_i.blit_width) begin
            x_q   <= '0;
            row_q <= row_q + RowStride;
            if (y_q == h_q) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              y_q     <= y_q + 1'b1;
              state_q <= S_BLIT_RD;
            end
          end else begin
            x_q     <= x_q + 1'b1;
            state_q <= S_BLIT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
